// ----- rtl/mtxinv_pkg.sv -----
// Shared constants, types and the cofactor index table for the 3x3 inverse unit.
// No dependencies; every other file imports this package.
package mtxinv_pkg;

  localparam int EW    = 32;            // element width, two's complement
  localparam int FRAC  = 16;            // fraction bits of an element
  localparam int NEL   = 9;             // elements of one matrix
  localparam int THR_W = 31;            // singular threshold width

  localparam int PW   = 2 * EW;         // cofactor product width
  localparam int CMW  = 2 * EW;         // cofactor magnitude width
  localparam int DMW  = 3 * EW;         // determinant magnitude width
  localparam int QW   = EW + 1;         // quotient bits kept
  localparam int NUMW = CMW + 2 * FRAC; // scaled numerator width
  localparam int DSW  = DMW + QW;       // divisor at its widest shift
  localparam int RW   = (NUMW > DSW) ? NUMW : DSW;
  localparam int THW  = THR_W + 2 * FRAC;
  localparam int CW   = (DMW > THW) ? DMW : THW;

  // operand indexes a, b, c, d of cofactor k = a*b - c*d, row-major
  localparam int COF_IDX [NEL][4] = '{
    '{4, 8, 7, 5}, '{7, 2, 1, 8}, '{1, 5, 4, 2},
    '{6, 5, 3, 8}, '{0, 8, 6, 2}, '{3, 2, 0, 5},
    '{3, 7, 6, 4}, '{6, 1, 0, 7}, '{0, 4, 3, 1}
  };

  typedef struct packed {
    logic [EW-1:0] elem;
    logic          ovf;
  } div_res_t;

  typedef struct packed {
    logic [DMW-1:0] mag;
    logic           neg;
    logic           sing;
  } det_res_t;

endpackage

// ----- rtl/matrix3x3_inverse_unit.sv -----
// Top level of the 3x3 matrix inverse unit: lanes, determinant, dividers, merge.
// Depends on mtxinv_pkg, mtxinv_cof, mtxinv_det and mtxinv_div.
//
// Usage:
//   s_axis carries one matrix per transfer, nine signed Q16.16 elements in
//   row-major order. m_axis returns the inverse in the same layout, with the
//   singular and overflow flags in tuser. cfg_data writes the singular
//   threshold (unsigned Q15.16 magnitude); write it only while the unit is idle.
//   Throughput: one matrix per cycle while s_axis_tready is high. A matrix
//   passes 3 cofactor stages, 4 determinant stages, 35 divider stages and
//   1 output register; the divider, one quotient bit per stage, is the
//   deepest part of the pipeline.
//   Reset clears all pipeline valids and the output valid, and sets the
//   threshold to one LSB. When the receiver stalls, the output register holds
//   its result while the pipeline keeps moving; the pipeline freezes, and
//   s_axis_tready drops, only when a finished matrix reaches the end behind a
//   held result. Singular matrices report zero elements and no overflow.
module matrix3x3_inverse_unit
  import mtxinv_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [NEL*EW-1:0] s_axis_tdata,   // r0c0, r0c1, ... r2c2, 32 bits each
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [NEL*EW-1:0] m_axis_tdata,   // r0c0, r0c1, ... r2c2, 32 bits each
  output logic [1:0]        m_axis_tuser,   // singular, overflow
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [31:0]       cfg_data        // singular_threshold in bits 30:0
);

  localparam int NCOF = 3;
  localparam int NDET = 4;
  localparam int NDIV = QW + 2;
  localparam int NST  = NCOF + NDET + NDIV;

  logic [THR_W-1:0]     thr;
  logic                 en;
  logic [NST-1:0]       vld;
  logic signed [EW-1:0] ein   [NEL];
  logic [CMW-1:0]       cmag  [NEL];
  logic                 cneg  [NEL];
  logic signed [EW-1:0] e_d   [3][NCOF];
  logic [CMW-1:0]       cm_d  [NEL][NDET];
  logic                 cn_d  [NEL][NDET];
  logic                 sing_d [NDIV];
  logic signed [EW-1:0] det_e [3];
  logic [CMW-1:0]       det_cm [3];
  logic                 det_cn [3];
  det_res_t             det;
  div_res_t             lane  [NEL];
  logic [NEL-1:0]       ovf_v;

  // Stall only when a result would overrun a held output
  assign en            = !(vld[NST-1] && m_axis_tvalid && !m_axis_tready);
  assign s_axis_tready = en;
  assign cfg_ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_W'(1);
    end else if (cfg_valid) begin
      thr <= cfg_data[THR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], s_axis_tvalid};
    end
  end

  // Cofactor lanes
  for (genvar k = 0; k < NEL; k++) begin : g_cof
    assign ein[k] = s_axis_tdata[k*EW +: EW];

    mtxinv_cof u_cof (
      .clk (clk),
      .en  (en),
      .a   (ein[COF_IDX[k][0]]),
      .b   (ein[COF_IDX[k][1]]),
      .c   (ein[COF_IDX[k][2]]),
      .d   (ein[COF_IDX[k][3]]),
      .mag (cmag[k]),
      .neg (cneg[k])
    );

    // hold cofactors until the determinant is ready
    always_ff @(posedge clk) begin
      if (en) begin
        cm_d[k][0] <= cmag[k];
        cn_d[k][0] <= cneg[k];
        for (int s = 1; s < NDET; s++) begin
          cm_d[k][s] <= cm_d[k][s-1];
          cn_d[k][s] <= cn_d[k][s-1];
        end
      end
    end
  end

  // Align first-row elements with their cofactors
  for (genvar j = 0; j < 3; j++) begin : g_row
    always_ff @(posedge clk) begin
      if (en) begin
        e_d[j][0] <= ein[j];
        for (int s = 1; s < NCOF; s++) begin
          e_d[j][s] <= e_d[j][s-1];
        end
      end
    end
    assign det_e[j]  = e_d[j][NCOF-1];
    assign det_cm[j] = cmag[3*j];
    assign det_cn[j] = cneg[3*j];
  end

  mtxinv_det u_det (
    .clk (clk),
    .en  (en),
    .e   (det_e),
    .cm  (det_cm),
    .cn  (det_cn),
    .thr (thr),
    .res (det)
  );

  // Divider lanes, one per element
  for (genvar k = 0; k < NEL; k++) begin : g_div
    mtxinv_div u_div (
      .clk  (clk),
      .en   (en),
      .cmag (cm_d[k][NDET-1]),
      .cneg (cn_d[k][NDET-1]),
      .dmag (det.mag),
      .dneg (det.neg),
      .res  (lane[k])
    );
    assign ovf_v[k] = lane[k].ovf;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sing_d[0] <= det.sing;
      for (int s = 1; s < NDIV; s++) begin
        sing_d[s] <= sing_d[s-1];
      end
    end
  end

  // Merge: zero a singular matrix, gather overflow, load the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else begin
      m_axis_tvalid <= (vld[NST-1] && en) || (m_axis_tvalid && !m_axis_tready);
    end
  end

  always_ff @(posedge clk) begin
    if (vld[NST-1] && en) begin
      for (int k = 0; k < NEL; k++) begin
        m_axis_tdata[k*EW +: EW] <= sing_d[NDIV-1] ? '0 : lane[k].elem;
      end
      m_axis_tuser[0] <= sing_d[NDIV-1];
      m_axis_tuser[1] <= !sing_d[NDIV-1] && (|ovf_v);
    end
  end

  a_sing_zero : assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("singular result carries nonzero elements");

  a_flags_excl : assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("singular and overflow both set");

  a_stall_cause : assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready && vld[NST-1])
    else $error("input stalled without a held output");

  a_pipe_to_out : assert property (@(posedge clk) disable iff (rst)
    vld[NST-1] && en |=> m_axis_tvalid)
    else $error("finished matrix did not reach the output");

endmodule

// ----- rtl/mtxinv_cof.sv -----
// One cofactor lane: a*b - c*d, returned as magnitude and sign after three stages.
// Depends on mtxinv_pkg.
module mtxinv_cof
  import mtxinv_pkg::*;
(
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [EW-1:0] a,
  input  logic signed [EW-1:0] b,
  input  logic signed [EW-1:0] c,
  input  logic signed [EW-1:0] d,
  output logic [CMW-1:0]       mag,
  output logic                 neg
);

  logic signed [PW-1:0] p_ab;
  logic signed [PW-1:0] p_cd;
  logic signed [PW:0]   diff;
  logic signed [PW:0]   diff_neg;

  assign diff_neg = -diff;

  always_ff @(posedge clk) begin
    if (en) begin
      p_ab <= a * b;
      p_cd <= c * d;
      diff <= {p_ab[PW-1], p_ab} - {p_cd[PW-1], p_cd};
      neg  <= diff[PW];
      mag  <= diff[PW] ? diff_neg[CMW-1:0] : diff[CMW-1:0];
    end
  end

endmodule

// ----- rtl/mtxinv_det.sv -----
// Determinant from the first row and its cofactors, plus the singular test.
// Four stages; depends on mtxinv_pkg.
module mtxinv_det
  import mtxinv_pkg::*;
(
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [EW-1:0] e   [3],
  input  logic [CMW-1:0]       cm  [3],
  input  logic                 cn  [3],
  input  logic [THR_W-1:0]     thr,
  output det_res_t             res
);

  localparam int SW = DMW + 3;

  logic [EW-1:0]         emag [3];
  logic [PW-1:0]         p_lo [3];
  logic [PW-1:0]         p_hi [3];
  logic                  sn   [3];
  logic [DMW-1:0]        tmag [3];
  logic signed [DMW:0]   term [3];
  logic signed [SW-1:0]  sum;
  logic [SW-1:0]         absv;

  for (genvar j = 0; j < 3; j++) begin : g_term
    assign emag[j] = e[j][EW-1] ? -e[j] : e[j];
    assign tmag[j] = DMW'(p_lo[j]) + (DMW'(p_hi[j]) << EW);

    always_ff @(posedge clk) begin
      if (en) begin
        p_lo[j] <= emag[j] * cm[j][EW-1:0];
        p_hi[j] <= emag[j] * cm[j][CMW-1:EW];
        sn[j]   <= e[j][EW-1] ^ cn[j];
        term[j] <= sn[j] ? -$signed({1'b0, tmag[j]}) : $signed({1'b0, tmag[j]});
      end
    end
  end

  assign absv = sum[SW-1] ? -sum : sum;

  always_ff @(posedge clk) begin
    if (en) begin
      sum      <= SW'(term[0]) + SW'(term[1]) + SW'(term[2]);
      res.neg  <= sum[SW-1];
      res.mag  <= absv[DMW-1:0];
      res.sing <= CW'(absv[DMW-1:0]) <= (CW'(thr) << (2 * FRAC));
    end
  end

endmodule

// ----- rtl/mtxinv_div.sv -----
// Divider lane: restoring division, one quotient bit per stage, then saturation.
// QW + 2 stages; depends on mtxinv_pkg.
module mtxinv_div
  import mtxinv_pkg::*;
(
  input  logic           clk,
  input  logic           en,
  input  logic [CMW-1:0] cmag,
  input  logic           cneg,
  input  logic [DMW-1:0] dmag,
  input  logic           dneg,
  output div_res_t       res
);

  localparam logic [QW-1:0] MAXP = QW'((64'd1 << (EW - 1)) - 64'd1);
  localparam logic [QW-1:0] MINM = QW'(64'd1 << (EW - 1));

  logic [RW-1:0]  rem [QW];
  logic [DMW-1:0] dv  [QW];
  logic [QW-1:0]  q   [QW+1];
  logic           ng  [QW+1];
  logic           hi  [QW+1];
  logic [RW-1:0]  num;
  logic [QW-1:0]  qneg;

  assign num  = RW'(cmag) << (2 * FRAC);
  assign qneg = -q[QW];

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= num;
      dv[0]  <= dmag;
      q[0]   <= '0;
      ng[0]  <= cneg ^ dneg;
      hi[0]  <= num >= (RW'(dmag) << QW);
    end
  end

  for (genvar s = 0; s < QW; s++) begin : g_bit
    localparam int SH = QW - 1 - s;
    logic [RW-1:0] dsh;
    logic          fit;
    assign dsh = RW'(dv[s]) << SH;
    assign fit = rem[s] >= dsh;

    always_ff @(posedge clk) begin
      if (en) begin
        q[s+1]  <= fit ? (q[s] | (QW'(1) << SH)) : q[s];
        ng[s+1] <= ng[s];
        hi[s+1] <= hi[s];
      end
    end

    if (s < QW - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem[s+1] <= fit ? rem[s] - dsh : rem[s];
          dv[s+1]  <= dv[s];
        end
      end
    end
  end

  // clamp to the element range
  always_ff @(posedge clk) begin
    if (en) begin
      if (ng[QW]) begin
        if (hi[QW] || q[QW] > MINM) begin
          res.elem <= MINM[EW-1:0];
          res.ovf  <= 1'b1;
        end else begin
          res.elem <= qneg[EW-1:0];
          res.ovf  <= 1'b0;
        end
      end else begin
        if (hi[QW] || q[QW] > MAXP) begin
          res.elem <= MAXP[EW-1:0];
          res.ovf  <= 1'b1;
        end else begin
          res.elem <= q[QW][EW-1:0];
          res.ovf  <= 1'b0;
        end
      end
    end
  end

endmodule

// ----- sim/matrix3x3_inverse_unit_tb.sv -----
// Self-checking bench for matrix3x3_inverse_unit: directed and random matrices,
// exact-arithmetic inverse prediction, random stalls on both streams.
// Depends on mtxinv_pkg and the unit's RTL only.
`timescale 1ns / 1ps

module matrix3x3_inverse_unit_tb;
  import mtxinv_pkg::*;

  typedef logic [NEL*EW-1:0] mat_t;

  typedef struct {
    mat_t       data;
    logic [1:0] flags;   // bit 0 singular, bit 1 overflow
  } inv_t;

  typedef struct {
    mat_t       mat;
    logic       typed;
    inv_t       want;
  } row_t;

  localparam logic [EW-1:0] ONE  = 32'h0001_0000;
  localparam logic [EW-1:0] MONE = 32'hFFFF_0000;
  localparam logic [EW-1:0] HALF = 32'h0000_8000;
  localparam logic [EW-1:0] EMAX = 32'h7FFF_FFFF;
  localparam logic [EW-1:0] EMIN = 32'h8000_0000;
  localparam logic [1:0] FLAG_SING = 2'b01;
  localparam logic [1:0] FLAG_OVF  = 2'b10;
  localparam int FLUSH_CYCLES = 60;

  logic clk, rst;
  logic s_axis_tvalid, s_axis_tready;
  mat_t s_axis_tdata;
  logic m_axis_tvalid, m_axis_tready;
  mat_t m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic cfg_valid, cfg_ready;
  logic [31:0] cfg_data;

  logic [THR_W-1:0] sing_thr;
  inv_t pending_inv[$];
  logic cur_typed;
  inv_t cur_want;
  bit   hold_rx;
  bit   failed;

  matrix3x3_inverse_unit u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Exact inverse through the adjugate; truncate toward zero, saturate.
  function automatic inv_t inverse_of(input mat_t m);
    logic signed [191:0] e [NEL];
    logic signed [191:0] cof [NEL];
    logic signed [191:0] det;
    logic [191:0] dmag, nmag, q, thr_scaled;
    logic neg;
    inv_t r;
    for (int k = 0; k < NEL; k++) e[k] = {{160{m[k*EW+EW-1]}}, m[k*EW +: EW]};
    for (int k = 0; k < NEL; k++)
      cof[k] = e[COF_IDX[k][0]] * e[COF_IDX[k][1]] - e[COF_IDX[k][2]] * e[COF_IDX[k][3]];
    det = e[0] * cof[0] + e[1] * cof[3] + e[2] * cof[6];
    dmag = (det < 0) ? -det : det;
    thr_scaled = {161'b0, sing_thr} << (2 * FRAC);
    r.data = '0;
    r.flags = '0;
    if (dmag <= thr_scaled) begin
      r.flags = FLAG_SING;
      return r;
    end
    for (int k = 0; k < NEL; k++) begin
      nmag = ((cof[k] < 0) ? -cof[k] : cof[k]) << (2 * FRAC);
      q = nmag / dmag;
      neg = ((cof[k] < 0) != (det < 0)) && (q != 0);
      if (neg) begin
        if (q > 192'h8000_0000) begin
          q = 192'h8000_0000;
          r.flags |= FLAG_OVF;
        end
        r.data[k*EW +: EW] = -q[EW-1:0];
      end else begin
        if (q > 192'h7FFF_FFFF) begin
          q = 192'h7FFF_FFFF;
          r.flags |= FLAG_OVF;
        end
        r.data[k*EW +: EW] = q[EW-1:0];
      end
    end
    return r;
  endfunction

  function automatic mat_t diag(input logic [EW-1:0] a, b, c);
    mat_t m;
    m = '0;
    m[0*EW +: EW] = a;
    m[4*EW +: EW] = b;
    m[8*EW +: EW] = c;
    return m;
  endfunction

  function automatic mat_t fill(input logic [EW-1:0] v);
    mat_t m;
    for (int k = 0; k < NEL; k++) m[k*EW +: EW] = v;
    return m;
  endfunction

  function automatic logic [EW-1:0] small_elem();
    // within +-4.0 so products stay well inside range
    return EW'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
  endfunction

  function automatic mat_t random_matrix();
    mat_t m;
    int kind, src;
    kind = $urandom_range(0, 9);
    for (int k = 0; k < NEL; k++) m[k*EW +: EW] = (kind < 4) ? $urandom() : small_elem();
    if (kind == 9) begin
      // copy one row onto another, then nudge one element: near singular
      src = $urandom_range(0, 2);
      for (int c = 0; c < 3; c++)
        m[(((src + 1) % 3) * 3 + c)*EW +: EW] = m[(src * 3 + c)*EW +: EW];
      m[$urandom_range(0, 8)*EW +: EW] += $urandom_range(0, 3);
    end else if (kind == 8) begin
      // diagonal with a tiny first entry pushes quotients toward saturation
      m = diag($urandom_range(1, 64) | ($urandom_range(0, 1) << 31),
               small_elem(), small_elem());
    end
    return m;
  endfunction

  // Input side: record the expectation of every matrix the unit accepts.
  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready)
      pending_inv.push_back(cur_typed ? cur_want : inverse_of(s_axis_tdata));
  end

  // Output side: compare each transfer with the oldest expectation.
  always @(posedge clk) begin
    inv_t w;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_inv.size() == 0) begin
        $display("%0t: unexpected result data=%h flags=%b", $time, m_axis_tdata, m_axis_tuser);
        failed = 1'b1;
      end else begin
        w = pending_inv.pop_front();
        for (int k = 0; k < NEL; k++)
          if (m_axis_tdata[k*EW +: EW] !== w.data[k*EW +: EW]) begin
            $display("%0t: element %0d expected %h actual %h", $time, k,
                     w.data[k*EW +: EW], m_axis_tdata[k*EW +: EW]);
            failed = 1'b1;
          end
        if (m_axis_tuser[0] !== w.flags[0]) begin
          $display("%0t: singular expected %b actual %b", $time, w.flags[0], m_axis_tuser[0]);
          failed = 1'b1;
        end
        if (m_axis_tuser[1] !== w.flags[1]) begin
          $display("%0t: overflow expected %b actual %b", $time, w.flags[1], m_axis_tuser[1]);
          failed = 1'b1;
        end
      end
    end
  end

  // Receiver: random stalls, one long hold-off on request.
  initial begin
    int n;
    m_axis_tready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_rx) begin
        n = 400;
        hold_rx = 1'b0;
      end else begin
        n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      end
      if (n > 0) begin
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  task automatic send_matrix(input mat_t m, input logic typed, input inv_t want,
                             input bit no_gap);
    int gap;
    gap = (no_gap || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tdata  <= m;
    s_axis_tvalid <= 1'b1;
    cur_typed <= typed;
    cur_want  <= want;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_inv.size() != 0) @(posedge clk);
    repeat (FLUSH_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [31:0] v);
    drain();
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sing_thr = v[THR_W-1:0];
  endtask

  task automatic random_burst(input int count, input bit no_gap);
    inv_t none;
    none = '{default: '0};
    repeat (count) send_matrix(random_matrix(), 1'b0, none, no_gap);
  endtask

  initial begin
    row_t rows[$];
    row_t r;
    inv_t none;
    logic [31:0] thr_list [5];

    none = '{default: '0};
    failed = 1'b0;
    hold_rx = 1'b0;
    sing_thr = 1;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    cur_typed = 1'b0;
    cur_want = none;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed rows under the reset threshold of one LSB
    rows.push_back('{diag(ONE, ONE, ONE), 1'b1, '{diag(ONE, ONE, ONE), 2'b00}});
    rows.push_back('{diag(MONE, MONE, MONE), 1'b1, '{diag(MONE, MONE, MONE), 2'b00}});
    rows.push_back('{diag(2 * ONE, 2 * ONE, 2 * ONE), 1'b1, '{diag(HALF, HALF, HALF), 2'b00}});
    rows.push_back('{mat_t'(0), 1'b1, '{mat_t'(0), FLAG_SING}});
    rows.push_back('{fill(EMAX), 1'b1, '{mat_t'(0), FLAG_SING}});
    rows.push_back('{fill(EMIN), 1'b1, '{mat_t'(0), FLAG_SING}});
    rows.push_back('{diag(1, 1, 1), 1'b1, '{mat_t'(0), FLAG_SING}});
    // determinant exactly on the threshold: still singular
    rows.push_back('{diag(1, ONE, ONE), 1'b1, '{mat_t'(0), FLAG_SING}});
    // one step above the threshold: positive quotient saturates
    rows.push_back('{diag(2, ONE, ONE), 1'b1, '{diag(EMAX, ONE, ONE), FLAG_OVF}});
    // negative tiny pivot reaches the most negative element without overflow
    rows.push_back('{diag(32'hFFFF_FFFE, ONE, ONE), 1'b1,
                     '{diag(EMIN, ONE, ONE), 2'b00}});
    rows.push_back('{diag(EMAX, EMAX, EMAX), 1'b0, none});
    rows.push_back('{diag(EMIN, EMIN, EMIN), 1'b0, none});
    rows.push_back('{diag(EMIN, EMAX, 32'hFFFF_FFFF), 1'b0, none});
    rows.push_back('{{9{32'hAAAA_5555}}, 1'b0, none});
    rows.push_back('{{9{32'h5555_AAAA}}, 1'b0, none});
    rows.push_back('{{ONE, 32'h0003_0000, 32'hFFFE_0000, 32'h0002_8000, ONE, EMAX,
                      MONE, 32'h0000_0001, 32'h0004_0000}, 1'b0, none});
    foreach (rows[i]) begin
      r = rows[i];
      send_matrix(r.mat, r.typed, r.want, 1'b0);
    end

    random_burst(150, 1'b0);

    // receiver holds off while the sender keeps going: pipeline fills, input stalls
    hold_rx = 1'b1;
    random_burst(120, 1'b1);

    // sender waits for every result before carrying on
    s_axis_tvalid <= 1'b0;
    while (pending_inv.size() != 0) @(posedge clk);
    random_burst(80, 1'b0);

    thr_list = '{32'h0000_0000, 32'h7FFF_FFFF, $urandom() & 32'h00FF_FFFF,
                 32'h8000_1234, 32'h0000_0001};
    foreach (thr_list[i]) begin
      write_threshold(thr_list[i]);
      random_burst(130, 1'b0);
    end

    drain();
    if (!failed)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #4_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/mtxinv_pkg.sv
rtl/mtxinv_cof.sv
rtl/mtxinv_det.sv
rtl/mtxinv_div.sv
rtl/matrix3x3_inverse_unit.sv
sim/matrix3x3_inverse_unit_tb.sv
